### rtl/core/pba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pba_pkg;

  // Map geometry.
  localparam int MAX_PAGES  = 4096;
  localparam int CELL_WIDTH = 32;
  localparam int CELL_COUNT = (MAX_PAGES + CELL_WIDTH - 1) / CELL_WIDTH;
  localparam int PAGE_W     = $clog2(MAX_PAGES);
  localparam int CNT_W      = PAGE_W + 1;
  localparam int OFF_W      = $clog2(CELL_WIDTH);
  localparam int CELL_AW    = $clog2(CELL_COUNT);

  // Operation codes.
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;
  localparam logic [1:0] ST_BAD_FREE  = 2'd3;

  // Configuration register indexes (word address bit 2).
  localparam logic REG_PAGE_COUNT = 1'b0;
  localparam logic REG_RESERVED   = 1'b1;

  // Register reset values.
  localparam logic [CNT_W-1:0] PAGE_COUNT_RST = CNT_W'(4096);
  localparam logic [CNT_W-1:0] RESERVED_RST   = CNT_W'(32);

  typedef logic [CELL_WIDTH-1:0] cell_t;

  // Configuration as seen by the engine.
  typedef struct packed {
    logic [CNT_W-1:0] page_lim;   // page_count clamped to MAX_PAGES
    logic [CNT_W-1:0] reserved;
  } cfg_t;

  // Bitmap memory request.
  typedef struct packed {
    logic               wr_en;
    logic [CELL_AW-1:0] wr_addr;
    cell_t              wr_data;
    logic               rd_en;
    logic [CELL_AW-1:0] rd_addr;
  } mem_req_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] granted_page;
    logic [CNT_W-1:0]  free_pages;
  } result_t;

  // Bit position of a one-hot cell word.
  function automatic logic [OFF_W-1:0] onehot_pos(input cell_t onehot);
    logic [OFF_W-1:0] pos;
    pos = '0;
    for (int j = 0; j < CELL_WIDTH; j++) begin
      if (onehot[j]) begin
        pos = pos | OFF_W'(j);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

### rtl/core/pba_bitmap_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pba_bitmap_ram (
  input  wire logic              clk,
  input  wire pba_pkg::mem_req_t req,
  output logic [pba_pkg::CELL_WIDTH-1:0] rd_data_r
);
  import pba_pkg::*;

  cell_t mem [CELL_COUNT];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/pba_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module pba_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  output pba_pkg::cfg_t    cfg
);
  import pba_pkg::*;

  logic [CNT_W-1:0] page_count_r;
  logic [CNT_W-1:0] reserved_r;
  logic             wr_stb;

  assign cfg_pready = 1'b1;
  assign wr_stb     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Register writes, decoded on the word address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r <= PAGE_COUNT_RST;
      reserved_r   <= RESERVED_RST;
    end else if (wr_stb) begin
      case (cfg_paddr[2])
        REG_PAGE_COUNT: page_count_r <= cfg_pwdata[CNT_W-1:0];
        REG_RESERVED:   reserved_r   <= cfg_pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (cfg_paddr[2])
      REG_PAGE_COUNT: cfg_prdata = 32'(page_count_r);
      REG_RESERVED:   cfg_prdata = 32'(reserved_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // A page count above the map size is limited to the map size.
  assign cfg.page_lim = (page_count_r > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : page_count_r;
  assign cfg.reserved = reserved_r;

endmodule

`default_nettype wire

### rtl/core/pba_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module pba_engine (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 in_op,
  input  wire logic [pba_pkg::PAGE_W-1:0] in_page,
  input  wire pba_pkg::cfg_t              cfg,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output pba_pkg::result_t                res,
  output pba_pkg::mem_req_t               mem_req,
  input  wire logic [pba_pkg::CELL_WIDTH-1:0] mem_rd_data
);
  import pba_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INIT     = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_FREE_CHK = 3'd3;
  localparam logic [2:0] S_DONE     = 3'd4;

  localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(CELL_COUNT - 1);

  logic [2:0]         state_r, state_nxt;
  logic               map_ready_r, map_ready_nxt;
  logic [CNT_W-1:0]   free_total_r, free_total_nxt;
  logic [CELL_AW-1:0] cell_r, cell_nxt;
  logic [PAGE_W-1:0]  page_r, page_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [PAGE_W-1:0]  granted_r, granted_nxt;

  logic [CNT_W-1:0]   init_total;
  logic               page_bad;
  cell_t              lo_mask, hi_mask, init_cell;
  cell_t              low_bit;
  logic [CNT_W-OFF_W-1:0] cell_ext;

  // Free count after init: pages between the reserve and the limit.
  assign init_total = (cfg.page_lim > cfg.reserved) ? (cfg.page_lim - cfg.reserved) : '0;

  // A free outside the managed, unreserved range is refused.
  assign page_bad = ({1'b0, in_page} >= cfg.page_lim) || ({1'b0, in_page} < cfg.reserved);

  // Init pattern of the current cell: pages at or above the reserve and below the limit.
  assign cell_ext = (CNT_W-OFF_W)'(cell_r);
  always_comb begin
    if (cfg.reserved[CNT_W-1:OFF_W] < cell_ext) begin
      lo_mask = '1;
    end else if (cfg.reserved[CNT_W-1:OFF_W] == cell_ext) begin
      lo_mask = '1 << cfg.reserved[OFF_W-1:0];
    end else begin
      lo_mask = '0;
    end
    if (cfg.page_lim[CNT_W-1:OFF_W] > cell_ext) begin
      hi_mask = '1;
    end else if (cfg.page_lim[CNT_W-1:OFF_W] == cell_ext) begin
      hi_mask = ~('1 << cfg.page_lim[OFF_W-1:0]);
    end else begin
      hi_mask = '0;
    end
    init_cell = lo_mask & hi_mask;
  end

  // Lowest set bit of the cell just read.
  assign low_bit = mem_rd_data & (~mem_rd_data + CELL_WIDTH'(1));

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res.status       = status_r;
  assign res.granted_page = granted_r;
  assign res.free_pages   = free_total_r;

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    map_ready_nxt  = map_ready_r;
    free_total_nxt = free_total_r;
    cell_nxt       = cell_r;
    page_nxt       = page_r;
    status_nxt     = status_r;
    granted_nxt    = granted_r;
    mem_req        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt  = ST_OK;
          granted_nxt = '0;
          case (in_op)
            OP_INIT: begin
              map_ready_nxt  = 1'b1;
              free_total_nxt = init_total;
              cell_nxt       = '0;
              state_nxt      = S_INIT;
            end
            OP_ALLOC: begin
              if (!map_ready_r) begin
                status_nxt = ST_NOT_READY;
                state_nxt  = S_DONE;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
                cell_nxt        = '0;
                state_nxt       = S_SCAN;
              end
            end
            OP_FREE: begin
              if (!map_ready_r) begin
                status_nxt = ST_NOT_READY;
                state_nxt  = S_DONE;
              end else if (page_bad) begin
                status_nxt = ST_BAD_FREE;
                state_nxt  = S_DONE;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = in_page[PAGE_W-1:OFF_W];
                page_nxt        = in_page;
                state_nxt       = S_FREE_CHK;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_INIT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = cell_r;
        mem_req.wr_data = init_cell;
        if (cell_r == LAST_CELL) begin
          state_nxt = S_DONE;
        end else begin
          cell_nxt = cell_r + CELL_AW'(1);
        end
      end
      S_SCAN: begin
        // The data of cell_r arrives in this cycle.
        if (mem_rd_data != '0) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = cell_r;
          mem_req.wr_data = mem_rd_data & ~low_bit;
          granted_nxt     = {cell_r, onehot_pos(low_bit)};
          if (free_total_r != '0) begin
            free_total_nxt = free_total_r - CNT_W'(1);
          end
          state_nxt = S_DONE;
        end else if (cell_r == LAST_CELL) begin
          status_nxt = ST_EMPTY;
          state_nxt  = S_DONE;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = cell_r + CELL_AW'(1);
          cell_nxt        = cell_r + CELL_AW'(1);
        end
      end
      S_FREE_CHK: begin
        if (mem_rd_data[page_r[OFF_W-1:0]]) begin
          status_nxt = ST_BAD_FREE;
        end else begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = page_r[PAGE_W-1:OFF_W];
          mem_req.wr_data = mem_rd_data | (CELL_WIDTH'(1) << page_r[OFF_W-1:0]);
          free_total_nxt  = free_total_r + CNT_W'(1);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      map_ready_r  <= 1'b0;
      free_total_r <= '0;
    end else begin
      state_r      <= state_nxt;
      map_ready_r  <= map_ready_nxt;
      free_total_r <= free_total_nxt;
    end
  end

  // Working registers of the current beat.
  always_ff @(posedge clk) begin
    cell_r    <= cell_nxt;
    page_r    <= page_nxt;
    status_r  <= status_nxt;
    granted_r <= granted_nxt;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_total_r <= CNT_W'(MAX_PAGES))
    else $error("free page count above map size");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> (state_r == S_INIT || state_r == S_SCAN || state_r == S_FREE_CHK))
    else $error("bitmap written outside a modify state");

  a_grant_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && mem_rd_data != '0) |=> (state_r == S_DONE && status_r == ST_OK))
    else $error("nonzero cell found but no grant reported");

  a_init_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && in_op == OP_INIT) |=> (state_r == S_INIT && map_ready_r))
    else $error("init did not start the fill sweep");

endmodule

`default_nettype wire

### rtl/core/page_bitmap_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Init sweeps all 128 bitmap cells, one write per cycle, then reports its result.
// Allocate scans cells from the lowest, one memory read per cycle, up to the first nonzero cell.
// Free reads its cell, then modifies and writes it back; early refusals and op 3 skip memory.
// One beat is in work at a time; a result waiting at the output does not stop the next accept.
// Reset (rst_n, synchronous) clears the free count and the ready flag; the map is not cleared,
// since every alloc and free before init is refused and init rewrites every cell.

module page_bitmap_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input beats.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [11:0] page_number, [15:12] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] op
  // Result beats.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // [11:0] granted_page, [24:12] free_pages, [31:25] zero
  output logic      [1:0]  out_tuser,  // [1:0] status
  // Configuration.
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import pba_pkg::*;

  cfg_t     cfg;
  mem_req_t mem_req;
  cell_t    mem_rd_data;
  logic     res_valid;
  logic     res_ready;
  result_t  res;
  logic     out_valid_r;
  result_t  out_res_r;

  pba_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pba_bitmap_ram u_ram (
    .clk       (clk),
    .req       (mem_req),
    .rd_data_r (mem_rd_data)
  );

  pba_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (in_tuser),
    .in_page     (in_tdata[PAGE_W-1:0]),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data)
  );

  // Output register: takes a new result when empty or being drained.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {7'b0, out_res_r.free_pages, out_res_r.granted_page};

endmodule

`default_nettype wire
